>>> rtl/ofp_pkg.sv
// Types, constants and rounding helpers shared by the orthonormal frame pipeline.
package ofp_pkg;

   // Port field widths
   localparam int CoordW = 32;
   localparam int OutW   = 16;

   // Internal fixed-point widths
   localparam int VecW     = 33;  // signed vector component entering a normalizer
   localparam int MagW     = 32;  // component magnitude
   localparam int LzW      = 6;   // leading zero count of a magnitude, 0..32
   localparam int NrmW     = 30;  // magnitude scaled so the largest lies in [2^29, 2^30)
   localparam int SqW      = 60;  // one squared magnitude
   localparam int SumW     = 62;  // sum of three squares
   localparam int RootAccW = 63;  // root accumulator of the square root
   localparam int LenW     = 31;  // vector length after the square root
   localparam int DivdW    = 61;  // dividend, magnitude in Q1.30 plus half the length
   localparam int RemW     = 32;  // divider partial remainder
   localparam int UnitW    = 32;  // signed Q1.30 unit component
   localparam int ProdW    = 64;  // signed Q2.60 product

   // Fixed-point constants
   localparam int UnitShift = 30;
   localparam int OutShift  = 16;
   localparam int OutOne    = 16384;

   // Pipeline depths of the normalizer
   localparam int SqrtSteps = 32;
   localparam int DivSteps  = 31;
   localparam int NormLat   = 5 + SqrtSteps + 1 + DivSteps + 1;

   typedef logic [2:0][VecW-1:0]  vec_type;
   typedef logic [2:0][UnitW-1:0] uvec_type;

   typedef struct packed {
      logic signed [CoordW-1:0] first_x;
      logic signed [CoordW-1:0] first_y;
      logic signed [CoordW-1:0] first_z;
      logic signed [CoordW-1:0] second_x;
      logic signed [CoordW-1:0] second_y;
      logic signed [CoordW-1:0] second_z;
   } req_type;

   typedef struct packed {
      logic signed [OutW-1:0] axis_x_0;
      logic signed [OutW-1:0] axis_x_1;
      logic signed [OutW-1:0] axis_x_2;
      logic signed [OutW-1:0] axis_y_0;
      logic signed [OutW-1:0] axis_y_1;
      logic signed [OutW-1:0] axis_y_2;
      logic signed [OutW-1:0] axis_z_0;
      logic signed [OutW-1:0] axis_z_1;
      logic signed [OutW-1:0] axis_z_2;
      logic                   degenerate;
   } rsp_type;

   // Magnitude of a signed vector component
   function automatic logic [MagW-1:0] mag_of(input logic [VecW-1:0] v);
      logic [VecW-1:0] n;
      n = v[VecW-1] ? (~v + 1'b1) : v;
      return n[MagW-1:0];
   endfunction

   // Q2.60 to Q1.30, round half away from zero
   function automatic logic [UnitW-1:0] round_q30(input logic [ProdW-1:0] v);
      logic [ProdW-1:0] m;
      logic [ProdW-1:0] r;
      m = v[ProdW-1] ? (~v + 1'b1) : v;
      r = (m + (ProdW'(1) << (UnitShift - 1))) >> UnitShift;
      if (v[ProdW-1]) r = ~r + 1'b1;
      return r[UnitW-1:0];
   endfunction

   // Q1.30 to Q2.14, round half away from zero, clamp to +/-1.0
   function automatic logic [OutW-1:0] to_q14(input logic [UnitW-1:0] v);
      logic [UnitW-1:0] m;
      logic [UnitW-1:0] r;
      m = v[UnitW-1] ? (~v + 1'b1) : v;
      r = (m + (UnitW'(1) << (OutShift - 1))) >> OutShift;
      if (r > UnitW'(OutOne)) r = UnitW'(OutOne);
      if (v[UnitW-1]) r = ~r + 1'b1;
      return r[OutW-1:0];
   endfunction

endpackage

>>> rtl/ofp_norm.sv
// Pipelined 3-vector normalizer: scale, sum of squares, square root, three dividers.
module ofp_norm (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ofp_pkg::vec_type  in_vec,
   output logic              out_valid,
   output ofp_pkg::uvec_type out_vec,
   output logic              out_zero
);
   import ofp_pkg::*;

   // valid bits travel alongside every stage
   logic [NormLat-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NormLat-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[NormLat-1];

   // stage 1: magnitudes and signs
   logic [2:0][MagW-1:0] m1_ff;
   logic [2:0]           s1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            m1_ff[i] <= mag_of(in_vec[i]);
            s1_ff[i] <= in_vec[i][VecW-1];
         end
      end
   end

   // stage 2: largest magnitude and its leading zero count
   logic [MagW-1:0]      mx;
   logic [LzW-1:0]       lz_in;
   logic [2:0][MagW-1:0] m2_ff;
   logic [2:0]           s2_ff;
   logic [LzW-1:0]       lz_ff;
   logic                 z2_ff;

   always_comb begin
      mx = m1_ff[0];
      if (m1_ff[1] > mx) mx = m1_ff[1];
      if (m1_ff[2] > mx) mx = m1_ff[2];
      lz_in = LzW'(MagW);
      for (int b = 0; b < MagW; b++) begin
         if (mx[b]) lz_in = LzW'(MagW - 1 - b);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_ff <= m1_ff;
         s2_ff <= s1_ff;
         lz_ff <= lz_in;
         z2_ff <= (mx == '0);
      end
   end

   // stage 3: bring the largest magnitude into [2^29, 2^30)
   logic [2:0][NrmW-1:0] n3_ff;
   logic [2:0]           s3_ff;
   logic                 z3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            n3_ff[i] <= NrmW'((m2_ff[i] << lz_ff) >> 2);
         end
         s3_ff <= s2_ff;
         z3_ff <= z2_ff;
      end
   end

   // stage 4: squares
   logic [2:0][SqW-1:0]  sq4_ff;
   logic [2:0][NrmW-1:0] n4_ff;
   logic [2:0]           s4_ff;
   logic                 z4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= SqW'(n3_ff[i]) * SqW'(n3_ff[i]);
         end
         n4_ff <= n3_ff;
         s4_ff <= s3_ff;
         z4_ff <= z3_ff;
      end
   end

   // stage 5 feeds the root pipeline: sum of squares, root cleared
   logic [SumW-1:0]      rt_n_ff [SqrtSteps+1];
   logic [RootAccW-1:0]  rt_r_ff [SqrtSteps+1];
   logic [2:0][NrmW-1:0] rt_m_ff [SqrtSteps+1];
   logic [2:0]           rt_s_ff [SqrtSteps+1];
   logic                 rt_z_ff [SqrtSteps+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rt_n_ff[0] <= SumW'(sq4_ff[0]) + SumW'(sq4_ff[1]) + SumW'(sq4_ff[2]);
         rt_r_ff[0] <= '0;
         rt_m_ff[0] <= n4_ff;
         rt_s_ff[0] <= s4_ff;
         rt_z_ff[0] <= z4_ff;
      end
   end

   // integer square root, one result bit per stage
   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      localparam logic [RootAccW-1:0] BitK = RootAccW'(1) << (2 * (SqrtSteps - 1 - k));
      logic [RootAccW-1:0] trial;
      logic                take;

      assign trial = rt_r_ff[k] + BitK;
      assign take  = (RootAccW'(rt_n_ff[k]) >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rt_n_ff[k+1] <= take ? SumW'(RootAccW'(rt_n_ff[k]) - trial) : rt_n_ff[k];
            rt_r_ff[k+1] <= take ? ((rt_r_ff[k] >> 1) + BitK) : (rt_r_ff[k] >> 1);
            rt_m_ff[k+1] <= rt_m_ff[k];
            rt_s_ff[k+1] <= rt_s_ff[k];
            rt_z_ff[k+1] <= rt_z_ff[k];
         end
      end
   end

   // divider setup: dividend is magnitude in Q1.30 plus half the length
   logic [LenW-1:0]          len;
   logic [2:0][DivdW-1:0]    divd;
   logic [2:0][RemW-1:0]     dv_rem_ff [DivSteps+1];
   logic [2:0][DivSteps-1:0] dv_low_ff [DivSteps+1];
   logic [LenW-1:0]          dv_len_ff [DivSteps+1];
   logic [2:0]               dv_s_ff   [DivSteps+1];
   logic                     dv_z_ff   [DivSteps+1];

   assign len = rt_r_ff[SqrtSteps][LenW-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         divd[i] = {1'b0, rt_m_ff[SqrtSteps][i], UnitShift'(0)} + DivdW'(len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= RemW'(divd[i][DivdW-1:DivSteps]);
            dv_low_ff[0][i] <= divd[i][DivSteps-1:0];
         end
         dv_len_ff[0] <= len;
         dv_s_ff[0]   <= rt_s_ff[SqrtSteps];
         dv_z_ff[0]   <= rt_z_ff[SqrtSteps];
      end
   end

   // restoring division, one quotient bit per stage in each lane
   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      logic [2:0][RemW-1:0] part;
      logic [2:0]           ge;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            part[i] = {dv_rem_ff[j][i][RemW-2:0], dv_low_ff[j][i][DivSteps-1]};
            ge[i]   = (part[i] >= RemW'(dv_len_ff[j]));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[j+1][i] <= ge[i] ? (part[i] - RemW'(dv_len_ff[j])) : part[i];
               dv_low_ff[j+1][i] <= {dv_low_ff[j][i][DivSteps-2:0], ge[i]};
            end
            dv_len_ff[j+1] <= dv_len_ff[j];
            dv_s_ff[j+1]   <= dv_s_ff[j];
            dv_z_ff[j+1]   <= dv_z_ff[j];
         end
      end
   end

   // restore signs
   uvec_type out_vec_ff;
   logic     out_zero_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            out_vec_ff[i] <= dv_s_ff[DivSteps][i]
                             ? (~UnitW'(dv_low_ff[DivSteps][i]) + 1'b1)
                             : UnitW'(dv_low_ff[DivSteps][i]);
         end
         out_zero_ff <= dv_z_ff[DivSteps];
      end
   end

   assign out_vec  = out_vec_ff;
   assign out_zero = out_zero_ff;

endmodule

>>> rtl/orthonormal_frame_from_points.sv
// Top level: orthonormal frame from two Q16.16 points, fully pipelined.
//
// Takes one point pair per cycle while req_ready is high and returns one frame per pair,
// in order. The path from transfer in to result valid is one difference stage, two
// normalizers of 70 stages each (the 32-stage square root and 31-stage dividers set that
// depth), four stages for the Y cross product and output rounding, and the output
// register. A skid register behind the output lets one more result finish while the
// output is stalled; req_ready drops only when both hold a result.
module orthonormal_frame_from_points (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ofp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ofp_pkg::rsp_type rsp_data
);
   import ofp_pkg::*;

   logic    en;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   // pipeline moves whenever the skid register is free
   assign en        = ~skid_valid_ff;
   assign req_ready = en;

   // difference stage
   logic    va_ff;
   vec_type d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= {req_data.first_x[CoordW-1], req_data.first_x}
                  - {req_data.second_x[CoordW-1], req_data.second_x};
         d_ff[1] <= {req_data.first_y[CoordW-1], req_data.first_y}
                  - {req_data.second_y[CoordW-1], req_data.second_y};
         d_ff[2] <= {req_data.first_z[CoordW-1], req_data.first_z}
                  - {req_data.second_z[CoordW-1], req_data.second_z};
      end
   end

   // X axis
   logic     xv;
   uvec_type xu;
   logic     xz;

   ofp_norm u_norm_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (va_ff),
      .in_vec    (d_ff),
      .out_valid (xv),
      .out_vec   (xu),
      .out_zero  (xz)
   );

   // X cross (1,1,0) direction, sign-extended
   vec_type cv;

   always_comb begin
      cv[0] = -{xu[2][UnitW-1], xu[2]};
      cv[1] = {xu[2][UnitW-1], xu[2]};
      cv[2] = {xu[0][UnitW-1], xu[0]} - {xu[1][UnitW-1], xu[1]};
   end

   // Z axis
   logic     zv;
   uvec_type zu;
   logic     zz;

   ofp_norm u_norm_z (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xv),
      .in_vec    (cv),
      .out_valid (zv),
      .out_vec   (zu),
      .out_zero  (zz)
   );

   // X and its degenerate flag wait alongside the Z normalizer
   uvec_type           xd_ff [NormLat];
   logic [NormLat-1:0] xdz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xd_ff[0]  <= xu;
         xdz_ff[0] <= xz;
         for (int i = 1; i < NormLat; i++) begin
            xd_ff[i]  <= xd_ff[i-1];
            xdz_ff[i] <= xdz_ff[i-1];
         end
      end
   end

   // back-end valid bits: products, differences, rounding, output format
   logic [3:0] tv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= '0;
      end else if (en) begin
         tv_ff <= {tv_ff[2:0], zv};
      end
   end

   // Y = Z x X: products
   logic [5:0][ProdW-1:0] p_ff;
   uvec_type              x1_ff, z1_ff;
   logic                  g1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= $signed(zu[1]) * $signed(xd_ff[NormLat-1][2]);
         p_ff[1] <= $signed(zu[2]) * $signed(xd_ff[NormLat-1][1]);
         p_ff[2] <= $signed(zu[2]) * $signed(xd_ff[NormLat-1][0]);
         p_ff[3] <= $signed(zu[0]) * $signed(xd_ff[NormLat-1][2]);
         p_ff[4] <= $signed(zu[0]) * $signed(xd_ff[NormLat-1][1]);
         p_ff[5] <= $signed(zu[1]) * $signed(xd_ff[NormLat-1][0]);
         x1_ff   <= xd_ff[NormLat-1];
         z1_ff   <= zu;
         g1_ff   <= xdz_ff[NormLat-1] | zz;
      end
   end

   // differences in Q2.60
   logic [2:0][ProdW-1:0] e_ff;
   uvec_type              x2_ff, z2_ff;
   logic                  g2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0] <= p_ff[0] - p_ff[1];
         e_ff[1] <= p_ff[2] - p_ff[3];
         e_ff[2] <= p_ff[4] - p_ff[5];
         x2_ff   <= x1_ff;
         z2_ff   <= z1_ff;
         g2_ff   <= g1_ff;
      end
   end

   // round to Q1.30
   uvec_type y3_ff, x3_ff, z3_ff;
   logic     g3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            y3_ff[i] <= round_q30(e_ff[i]);
         end
         x3_ff <= x2_ff;
         z3_ff <= z2_ff;
         g3_ff <= g2_ff;
      end
   end

   // output format; degenerate frames are all zero
   rsp_type fin_in;
   rsp_type fin_ff;

   always_comb begin
      fin_in = '0;
      fin_in.degenerate = g3_ff;
      if (!g3_ff) begin
         fin_in.axis_x_0 = to_q14(x3_ff[0]);
         fin_in.axis_x_1 = to_q14(x3_ff[1]);
         fin_in.axis_x_2 = to_q14(x3_ff[2]);
         fin_in.axis_y_0 = to_q14(y3_ff[0]);
         fin_in.axis_y_1 = to_q14(y3_ff[1]);
         fin_in.axis_y_2 = to_q14(y3_ff[2]);
         fin_in.axis_z_0 = to_q14(z3_ff[0]);
         fin_in.axis_z_1 = to_q14(z3_ff[1]);
         fin_in.axis_z_2 = to_q14(z3_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= fin_in;
      end
   end

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= tv_ff[3];
         end
      end else if (tv_ff[3] && en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : fin_ff;
      end else if (tv_ff[3] && en) begin
         skid_data_ff <= fin_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // skid holds a result only behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output empty");

   // skid fills only on a stalled output transfer
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid filled without output stall");

   // input stalls only with both result registers occupied
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && skid_valid_ff))
      else $error("input stalled with room downstream");

   // degenerate frames carry zero axes
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.degenerate) |->
         (rsp_data_ff.axis_x_0 == '0 && rsp_data_ff.axis_y_1 == '0
          && rsp_data_ff.axis_z_2 == '0))
      else $error("degenerate frame with nonzero axis");

endmodule
